>>> sv/text_console_cursor_scroll_macros.svh
// Assertion macros shared by the text console RTL.
// Expects aclk and aresetn to be visible in the module that uses them.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("text console check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("text console check failed");

`endif

>>> sv/tccs_pkg.sv
// Shared types and constants for the text console with cursor and scrolling.
// No dependencies; every other RTL file imports this package.
package tccs_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_STOP    = 8;   // must stay a power of two
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int SCROLL_LAST = CELL_COUNT - COLUMNS;
    localparam int QUEUE_DEPTH = 2;

    localparam int CELL_W  = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int DATA_W  = 16;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_BACKSPACE,
        CMD_TAB,
        CMD_NEWLINE,
        CMD_IGNORE,
        CMD_CLEAR,
        CMD_READ,
        CMD_READ_ZERO
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        char_code;
        logic [3:0]        bg_nibble;
        logic [3:0]        fg_nibble;
        logic [CELL_W-1:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cursor_location;
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_column_out;
        logic [DATA_W-1:0] read_data;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] cell_word;
        logic [CELL_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

>>> sv/text_console_cursor_scroll.sv
// Text console over an 80x25 buffer of 16-bit cells with cursor, wrap and scroll.
// A put, read or ignored item passes the queue, then the idle, read (reads only) and done states.
// A scroll copies rows up and blanks the last row, a clear blanks all cells, one memory write per cycle.
// A two-entry command queue takes input while the back end is busy.
// After reset a clearing pass blanks every cell of the memory; no input is taken meanwhile.
// Depends on tccs_pkg, tccs_front, tccs_cmd_queue and tccs_back.
module text_console_cursor_scroll import tccs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    queue_status_t q_status;
    back_status_t  b_status;
    logic          push, pop;
    cmd_t          push_cmd, pop_cmd;

    tccs_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .b_status (b_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tccs_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    tccs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .cmd      (pop_cmd),
        .pop      (pop),
        .status   (b_status),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

>>> sv/tccs_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Depends on tccs_pkg.
module tccs_front import tccs_pkg::*; (
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_data,
    input  queue_status_t q_status,
    input  back_status_t  b_status,
    output logic          push,
    output cmd_t          push_cmd
);

    cmd_kind_t char_kind;

    assign s_ready = !q_status.full && !b_status.init_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        priority if (s_data.char_code == CHAR_BS) begin
            char_kind = CMD_BACKSPACE;
        end else if (s_data.char_code == CHAR_TAB) begin
            char_kind = CMD_TAB;
        end else if (s_data.char_code == CHAR_CR || s_data.char_code == CHAR_LF) begin
            char_kind = CMD_NEWLINE;
        end else if (s_data.char_code >= CHAR_PRINT_LO && s_data.char_code <= CHAR_PRINT_HI) begin
            char_kind = CMD_PUT;
        end else begin
            char_kind = CMD_IGNORE;
        end
    end

    always_comb begin
        push_cmd.cell_word = {s_data.bg_nibble, s_data.fg_nibble, s_data.char_code};
        push_cmd.index     = s_data.cell_index;
        unique case (s_data.opcode)
            OP_PUT:   push_cmd.kind = char_kind;
            OP_CLEAR: push_cmd.kind = CMD_CLEAR;
            OP_READ: begin
                // Addresses past the last cell read back as zero.
                if (int'(s_data.cell_index) < CELL_COUNT) begin
                    push_cmd.kind = CMD_READ;
                end else begin
                    push_cmd.kind = CMD_READ_ZERO;
                end
            end
            OP_NONE:  push_cmd.kind = CMD_IGNORE;
            default:  push_cmd.kind = CMD_IGNORE;
        endcase
    end

endmodule

>>> sv/tccs_cmd_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on tccs_pkg and the assertion macro header.
`include "text_console_cursor_scroll_macros.svh"

module tccs_cmd_queue import tccs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          pop_cmd,
    output queue_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `TCCS_ASSERT_IMPL(a_no_push_full, push, !status.full)
    `TCCS_ASSERT_IMPL(a_no_pop_empty, pop, !status.empty)
    `TCCS_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `TCCS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))

endmodule

>>> sv/tccs_back.sv
// Back end: executes commands against the cell memory and cursor, drives results.
// Depends on tccs_pkg and the assertion macro header.
`include "text_console_cursor_scroll_macros.svh"

module tccs_back import tccs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  cmd_t          cmd,
    output logic          pop,
    output back_status_t  status,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_data
);

    back_state_t       state_reg, state_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [DATA_W-1:0] mem [CELL_COUNT];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we, mem_re;
    logic [CELL_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    // Effect of a put-type command on the cursor.
    logic [CELL_W-1:0] cur_addr;
    logic [COL_W:0]    col_w, put_col_w;
    logic [ROW_W:0]    put_row_w;
    logic              put_we, put_scroll;
    logic [CELL_W-1:0] put_addr;
    logic [DATA_W-1:0] put_data;

    logic last_cell, last_copy;

    assign cur_addr  = CELL_W'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign col_w     = {1'b0, col_reg};
    assign last_cell = (cnt_reg == CELL_W'(CELL_COUNT - 1));
    assign last_copy = (cnt_reg == CELL_W'(SCROLL_LAST));

    always_comb begin
        put_col_w = col_w;
        put_row_w = {1'b0, row_reg};
        put_we    = 1'b0;
        put_addr  = cur_addr;
        put_data  = cmd.cell_word;
        unique case (cmd.kind)
            CMD_PUT: begin
                put_we    = 1'b1;
                put_col_w = col_w + 1'b1;
            end
            CMD_BACKSPACE: begin
                if (col_reg != '0) begin
                    put_we    = 1'b1;
                    put_addr  = cur_addr - 1'b1;
                    put_data  = BLANK_CELL;
                    put_col_w = col_w - 1'b1;
                end
            end
            CMD_TAB: begin
                put_col_w = (COL_W+1)'((int'(col_w) / TAB_STOP + 1) * TAB_STOP);
            end
            CMD_NEWLINE: begin
                put_col_w = '0;
                put_row_w = put_row_w + 1'b1;
            end
            default: begin
            end
        endcase
        if (put_col_w >= (COL_W+1)'(COLUMNS)) begin
            put_col_w = '0;
            put_row_w = put_row_w + 1'b1;
        end
        put_scroll = (put_row_w >= (ROW_W+1)'(ROWS));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_status.empty) begin
                    unique case (cmd.kind)
                        CMD_CLEAR:     state_next = ST_BLANK;
                        CMD_READ:      state_next = ST_READ;
                        CMD_READ_ZERO: state_next = ST_DONE;
                        CMD_IGNORE:    state_next = ST_DONE;
                        default:       state_next = put_scroll ? ST_SCROLL : ST_DONE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_DONE;
            ST_SCROLL: begin
                if (last_copy) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (last_cell) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = cnt_reg;
        mem_raddr    = cmd.index;
        mem_wdata    = BLANK_CELL;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        data_next    = data_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_INIT, ST_BLANK: begin
                mem_we   = 1'b1;
                cnt_next = last_cell ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop       = 1'b1;
                    data_next = '0;
                    cnt_next  = '0;
                    unique case (cmd.kind)
                        CMD_CLEAR: begin
                            row_next = '0;
                            col_next = '0;
                        end
                        CMD_READ: begin
                            mem_re = 1'b1;
                        end
                        CMD_READ_ZERO, CMD_IGNORE: begin
                        end
                        default: begin
                            mem_we    = put_we;
                            mem_waddr = put_addr;
                            mem_wdata = put_data;
                            col_next  = put_col_w[COL_W-1:0];
                            row_next  = put_scroll ? ROW_W'(ROWS - 1) : put_row_w[ROW_W-1:0];
                        end
                    endcase
                end
            end
            ST_READ: begin
                data_next = rdata_reg;
            end
            ST_SCROLL: begin
                // Read one row below, write the cell read in the previous cycle.
                if (!last_copy) begin
                    mem_re    = 1'b1;
                    mem_raddr = CELL_W'(int'(cnt_reg) + COLUMNS);
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - 1'b1;
                    mem_wdata = rdata_reg;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_data_next.cursor_location   = cur_addr;
                    m_data_next.cursor_row_out    = row_reg;
                    m_data_next.cursor_column_out = col_reg;
                    m_data_next.read_data         = data_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign status.init_busy = (state_reg == ST_INIT);
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;

    `TCCS_ASSERT_IMPL(a_pop_only_idle, pop, state_reg == ST_IDLE)
    `TCCS_ASSERT_IMPL(a_result_from_done, !m_valid_reg && m_valid_next, state_reg == ST_DONE)
    `TCCS_ASSERT_IMPL(a_cursor_bounds, 1'b1,
        int'(row_reg) < ROWS && int'(col_reg) < COLUMNS)
    `TCCS_ASSERT_NEXT(a_scroll_last_row, state_reg == ST_SCROLL, row_reg == ROW_W'(ROWS - 1))

endmodule

>>> tb/sv/tb_text_console_cursor_scroll.sv
// Self-checking testbench for text_console_cursor_scroll: directed probes, then random traffic.
// A cell-accurate screen model predicts every result not typed into a probe; depends on tccs_pkg and the RTL only.
module tb_text_console_cursor_scroll;
    import tccs_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        in_item_t  stim;
        bit        typed_ok;
        out_item_t typed_res;
    } probe_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Screen model and cursor as seen after each accepted transaction.
    logic [DATA_W-1:0] screen_mem [0:CELL_COUNT-1];
    int unsigned       cur_row;
    int unsigned       cur_col;

    out_item_t   pending_results [$];
    probe_row_t  probe_rows [$];
    int unsigned fault_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    text_console_cursor_scroll dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) screen_mem[i] = BLANK_CELL;
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic out_item_t console_step(input in_item_t item);
        out_item_t res;
        logic [7:0] code;
        logic [7:0] attr;
        code = item.char_code;
        attr = {item.bg_nibble, item.fg_nibble};
        res  = '0;
        case (opcode_t'(item.opcode))
            OP_PUT: begin
                if (code == CHAR_BS) begin
                    if (cur_col != 0) begin
                        cur_col--;
                        screen_mem[cur_row * COLUMNS + cur_col] = BLANK_CELL;
                    end
                end else if (code == CHAR_TAB) begin
                    cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
                end else if (code == CHAR_CR || code == CHAR_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI) begin
                    screen_mem[cur_row * COLUMNS + cur_col] = {attr, code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // Leaving the last row shifts everything up one line.
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_mem[i] = screen_mem[i + COLUMNS];
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_mem[i] = BLANK_CELL;
                    cur_row = ROWS - 1;
                end
            end
            OP_CLEAR: blank_screen();
            OP_READ: begin
                if (item.cell_index < CELL_COUNT) res.read_data = screen_mem[item.cell_index];
            end
            default: ;
        endcase
        res.cursor_location   = CELL_W'(cur_row * COLUMNS + cur_col);
        res.cursor_row_out    = ROW_W'(cur_row);
        res.cursor_column_out = COL_W'(cur_col);
        return res;
    endfunction

    function automatic void add_probe(input opcode_t op, input logic [7:0] code,
                                      input logic [3:0] back, input logic [3:0] fore,
                                      input logic [CELL_W-1:0] idx, input bit typed_ok,
                                      input int loc, input int row, input int col,
                                      input logic [DATA_W-1:0] data);
        probe_row_t p;
        p.stim.opcode                 = op;
        p.stim.char_code              = code;
        p.stim.bg_nibble              = back;
        p.stim.fg_nibble              = fore;
        p.stim.cell_index             = idx;
        p.typed_ok                    = typed_ok;
        p.typed_res.cursor_location   = CELL_W'(loc);
        p.typed_res.cursor_row_out    = ROW_W'(row);
        p.typed_res.cursor_column_out = COL_W'(col);
        p.typed_res.read_data         = data;
        probe_rows.push_back(p);
    endfunction

    function automatic in_item_t random_item();
        in_item_t item;
        int unsigned pick;
        int unsigned here;
        item.opcode     = OP_PUT;
        item.char_code  = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
        item.bg_nibble  = 4'($urandom_range(0, 15));
        item.fg_nibble  = 4'($urandom_range(0, 15));
        item.cell_index = CELL_W'($urandom);
        here = cur_row * COLUMNS + cur_col;
        pick = $urandom_range(0, 99);
        if (pick < 54) begin
            // Printable character, already set up above.
        end else if (pick < 62) begin
            item.char_code = CHAR_TAB;
        end else if (pick < 70) begin
            item.char_code = CHAR_LF;
        end else if (pick < 76) begin
            item.char_code = CHAR_CR;
        end else if (pick < 80) begin
            item.char_code = CHAR_BS;
        end else if (pick < 83) begin
            item.char_code = $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                                  : 8'($urandom_range(0, 31));
        end else if (pick < 96) begin
            item.opcode = OP_READ;
            item.char_code = 8'($urandom);
            // Most reads look behind the cursor, where recent writes and scrolls landed.
            case ($urandom_range(0, 7))
                0:       item.cell_index = CELL_W'($urandom_range(CELL_COUNT, 2047));
                1, 2:    item.cell_index = CELL_W'($urandom_range(0, CELL_COUNT - 1));
                default: item.cell_index = CELL_W'((here > 160) ? here - $urandom_range(0, 160)
                                                                : $urandom_range(0, here));
            endcase
        end else if (pick < 98) begin
            item.opcode = OP_NONE;
            item.char_code = 8'($urandom);
        end else if (pick < 99) begin
            item.opcode = OP_CLEAR;
            item.char_code = 8'($urandom);
        end
        return item;
    endfunction

    task automatic drive_one(input in_item_t item, input bit typed_ok,
                             input out_item_t typed_res);
        out_item_t predicted;
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predicted = console_step(item);
        pending_results.push_back(typed_ok ? typed_res : predicted);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected transaction, expected none, actual %0h",
                         $time, m_data);
            end else begin
                want = pending_results.pop_front();
                check_field("cursor_location", DATA_W'(want.cursor_location),
                            DATA_W'(m_data.cursor_location));
                check_field("cursor_row_out", DATA_W'(want.cursor_row_out),
                            DATA_W'(m_data.cursor_row_out));
                check_field("cursor_column_out", DATA_W'(want.cursor_column_out),
                            DATA_W'(m_data.cursor_column_out));
                check_field("read_data", want.read_data, m_data.read_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_text_console_cursor_scroll: done, errors");
            $finish;
        end
    end

    initial begin
        blank_screen();
        // Reset state, extremes of the fields and every control byte that the console acts on.
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 0,   0, 0, BLANK_CELL);
        add_probe(OP_READ,  8'hFF, 4'hF, 4'hF, 11'd1999, 1, 0,   0, 0, BLANK_CELL);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd2047, 1, 0,   0, 0, 16'h0000);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd2000, 1, 0,   0, 0, 16'h0000);
        add_probe(OP_PUT,   CHAR_BS, 4'h3, 4'h4, 11'd0,  1, 0,   0, 0, 16'h0000);
        add_probe(OP_PUT,   8'h20, 4'h0, 4'h0, 11'd2047, 1, 1,   0, 1, 16'h0000);
        add_probe(OP_PUT,   8'h7F, 4'hF, 4'hF, 11'd0,    1, 2,   0, 2, 16'h0000);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd1,    1, 2,   0, 2, 16'hFF7F);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 2,   0, 2, 16'h0020);
        add_probe(OP_PUT,   CHAR_BS, 4'h0, 4'h0, 11'd0,  1, 1,   0, 1, 16'h0000);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd1,    1, 1,   0, 1, BLANK_CELL);
        add_probe(OP_PUT,   CHAR_TAB, 4'h0, 4'h0, 11'd0, 1, 8,   0, 8, 16'h0000);
        add_probe(OP_PUT,   8'h1F, 4'h1, 4'h2, 11'd0,    1, 8,   0, 8, 16'h0000);
        add_probe(OP_PUT,   8'h80, 4'h1, 4'h2, 11'd0,    1, 8,   0, 8, 16'h0000);
        add_probe(OP_PUT,   8'hFF, 4'hF, 4'hF, 11'd0,    1, 8,   0, 8, 16'h0000);
        add_probe(OP_PUT,   8'h00, 4'h0, 4'h0, 11'd0,    1, 8,   0, 8, 16'h0000);
        add_probe(OP_PUT,   8'h41, 4'hA, 4'h5, 11'd0,    0, 0,   0, 0, 16'h0000);
        add_probe(OP_PUT,   CHAR_CR, 4'h0, 4'h0, 11'd0,  0, 0,   0, 0, 16'h0000);
        add_probe(OP_PUT,   CHAR_LF, 4'h0, 4'h0, 11'd0,  0, 0,   0, 0, 16'h0000);
        add_probe(OP_NONE,  8'h55, 4'h6, 4'h9, 11'd8,    1, 160, 2, 0, 16'h0000);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd8,    0, 0,   0, 0, 16'h0000);
        add_probe(OP_CLEAR, 8'hAA, 4'h5, 4'hA, 11'd1365, 1, 0,   0, 0, 16'h0000);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd8,    1, 0,   0, 0, BLANK_CELL);
        add_probe(OP_PUT,   8'h7E, 4'hF, 4'h0, 11'd0,    0, 0,   0, 0, 16'h0000);
        add_probe(OP_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 1,   0, 1, 16'hF07E);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_rows[i])
            drive_one(probe_rows[i].stim, probe_rows[i].typed_ok, probe_rows[i].typed_res);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i * 5) / RANDOM_ITEMS)
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                3:       begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            drive_one(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("tb_text_console_cursor_scroll: done, clean");
        end else begin
            $display("tb_text_console_cursor_scroll: done, errors");
        end
        $finish;
    end

endmodule
